// ===== sv/ray_box_slab_intersect_assert.svh =====
// Assertion helpers shared by the ray/box intersection RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rbsi_pkg.sv =====
`timescale 1ns / 1ps
package rbsi_pkg;

   // Default fraction bits of the fixed-point format.
   localparam int unsigned FRAC_BITS_DEF = 16;
   // Default depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   // Direction magnitudes below this (raw units) use the clamp reciprocal.
   localparam logic [31:0] DIR_LIMIT = 32'd16;

   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

   // Face codes of the result.
   localparam logic [2:0] FACE_NONE  = 3'd0;
   localparam logic [2:0] FACE_POS_Z = 3'd1;
   localparam logic [2:0] FACE_NEG_Z = 3'd2;
   localparam logic [2:0] FACE_POS_Y = 3'd3;
   localparam logic [2:0] FACE_NEG_Y = 3'd4;
   localparam logic [2:0] FACE_POS_X = 3'd5;
   localparam logic [2:0] FACE_NEG_X = 3'd6;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_BOX_MAX_X     = 3'd0,
      CSR_BOX_MAX_Y     = 3'd1,
      CSR_BOX_MAX_Z     = 3'd2,
      CSR_BOX_MIN_X     = 3'd3,
      CSR_BOX_MIN_Y     = 3'd4,
      CSR_BOX_MIN_Z     = 3'd5,
      CSR_SNAP_MARGIN   = 3'd6,
      CSR_INV_DIR_CLAMP = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] t_low;
      logic signed [31:0] t_high;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_t;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [2:0]         face_code;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] box_max;
      logic [2:0][31:0] box_min;
      logic [30:0]      snap_margin;
      logic [31:0]      inv_dir_clamp;
   } cfg_type;

   // A classified request as it travels from front to back.
   typedef struct packed {
      logic [2:0][31:0] org;
      logic [2:0][31:0] dir;
      logic [2:0][31:0] off_hi;
      logic [2:0][31:0] off_lo;
      logic [2:0][31:0] dmag;
      logic [2:0]       dneg;
      logic [2:0]       dsmall;
      logic [31:0]      t_low;
      logic [31:0]      t_high;
   } work_type;

   // Saturate a signed 64-bit value to 32 bits.
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/ray_box_slab_intersect.sv =====
`timescale 1ns / 1ps
// Ray against one axis-aligned box by the slab method, in signed fixed point
// with FRAC_BITS fraction bits. The box corners, snap margin and tiny-direction
// reciprocal are written through the csr_ port; the user must write them only
// while no request is in flight, which the block does not enforce. One request
// is accepted per cycle while req_ready is high, and each gives exactly one
// result, in order. The reciprocal divider resolves one quotient bit per pipeline
// stage for each axis. A request register and a queue of QUEUE_DEPTH entries sit
// in front of the arithmetic pipeline, and the pipeline halts as a whole while
// the result register is held.
module ray_box_slab_intersect #(
   parameter int unsigned FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
   parameter int unsigned QUEUE_DEPTH = rbsi_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rbsi_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rbsi_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   rbsi_pkg::cfg_type   cfg_ff, cfg_in;
   rbsi_pkg::work_type  fq_data;
   rbsi_pkg::work_type  qb_data;
   logic                fq_valid;
   logic                fq_ready;
   logic                qb_valid;
   logic                qb_pop;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (rbsi_pkg::csr_idx_type'(csr_index))
            rbsi_pkg::CSR_BOX_MAX_X:     cfg_in.box_max[0]    = csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Y:     cfg_in.box_max[1]    = csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Z:     cfg_in.box_max[2]    = csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_X:     cfg_in.box_min[0]    = csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Y:     cfg_in.box_min[1]    = csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Z:     cfg_in.box_min[2]    = csr_wdata;
            rbsi_pkg::CSR_SNAP_MARGIN:   cfg_in.snap_margin   = csr_wdata[30:0];
            rbsi_pkg::CSR_INV_DIR_CLAMP: cfg_in.inv_dir_clamp = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_max       <= {3{32'd65536}};
         cfg_ff.box_min       <= '0;
         cfg_ff.snap_margin   <= 31'd16;
         cfg_ff.inv_dir_clamp <= 32'h7FFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   rbsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_pop   (qb_pop),
      .out_data  (qb_data)
   );

   rbsi_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (qb_valid),
      .q_pop     (qb_pop),
      .q_data    (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/rbsi_front.sv =====
`timescale 1ns / 1ps
module rbsi_front (
   input  logic                clock,
   input  logic                reset,
   input  rbsi_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  rbsi_pkg::req_type   req_data,
   output logic                q_valid,
   input  logic                q_ready,
   output rbsi_pkg::work_type  q_data
);

   rbsi_pkg::req_type  req_ff, req_in;
   logic               req_v_ff, req_v_in;
   logic [2:0][31:0]   org;
   logic [2:0][31:0]   dir;

   // Offset from origin to a box plane, snapped to the margin when tiny.
   function automatic logic [31:0] snap_off(input logic [31:0] plane, input logic [31:0] o,
                                            input logic [30:0] margin);
      logic signed [32:0] off;
      logic [32:0]        mag;
      logic [31:0]        r;
      off = $signed({plane[31], plane}) - $signed({o[31], o});
      mag = off[32] ? 33'(-off) : off;
      if (mag < {2'b00, margin}) begin
         r = {1'b0, margin};
      end else begin
         r = rbsi_pkg::sat32({{31{off[32]}}, off});
      end
      return r;
   endfunction

   // The request register accepts whenever it is empty or drains into the queue.
   assign req_ready = !req_v_ff || q_ready;
   assign q_valid   = req_v_ff;

   always_comb begin
      req_in   = req_ff;
      req_v_in = req_v_ff;
      if (req_valid && req_ready) begin
         req_in   = req_data;
         req_v_in = 1'b1;
      end else if (q_ready) begin
         req_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else begin
         req_v_ff <= req_v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Classification: snapped offsets, direction magnitude and tiny-direction flags.
   assign org = {req_ff.origin_z, req_ff.origin_y, req_ff.origin_x};
   assign dir = {req_ff.dir_z, req_ff.dir_y, req_ff.dir_x};

   always_comb begin
      q_data.org    = org;
      q_data.dir    = dir;
      q_data.t_low  = req_ff.t_low;
      q_data.t_high = req_ff.t_high;
      for (int i = 0; i < 3; i++) begin
         q_data.off_hi[i] = snap_off(cfg.box_max[i], org[i], cfg.snap_margin);
         q_data.off_lo[i] = snap_off(cfg.box_min[i], org[i], cfg.snap_margin);
         q_data.dneg[i]   = dir[i][31];
         q_data.dmag[i]   = dir[i][31] ? 32'(-dir[i]) : dir[i];
         q_data.dsmall[i] = q_data.dmag[i] < rbsi_pkg::DIR_LIMIT;
      end
   end

endmodule

// ===== sv/rbsi_queue.sv =====
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_assert.svh"
module rbsi_queue #(
   parameter int unsigned DEPTH = rbsi_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rbsi_pkg::work_type  in_data,
   output logic                out_valid,
   input  logic                out_pop,
   output rbsi_pkg::work_type  out_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rbsi_pkg::work_type  mem_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                push;
   logic                pop;

   assign in_ready  = cnt_ff != CW'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   // The fill count never passes the depth.
   `RBSI_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(DEPTH), "queue count overflow")

   // A pop without a push lowers the count by one.
   `RBSI_ASSERT_NEXT(a_pop_dec, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1, "queue pop lost")

endmodule

// ===== sv/rbsi_back.sv =====
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_assert.svh"
module rbsi_back #(
   parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rbsi_pkg::cfg_type   cfg,
   input  logic                q_valid,
   output logic                q_pop,
   input  rbsi_pkg::work_type  q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rbsi_pkg::rsp_type   rsp_data
);

   // Quotient bits of 2^(2*FRAC_BITS) / |d|, one per divider stage.
   localparam int unsigned DW = 2 * FRAC_BITS + 1;

   logic adv;

   // Divider pipeline.
   logic                div_v_ff   [DW];
   rbsi_pkg::work_type  div_w_ff   [DW];
   logic [2:0][31:0]    div_rem_ff [DW];
   logic [2:0][DW-1:0]  div_q_ff   [DW];

   // Post-divider stages.
   logic [5:0]                p_v_ff;
   rbsi_pkg::work_type        p1_w_ff, p2_w_ff, p3_w_ff;
   logic [2:0][31:0]          p4_org_ff, p5_org_ff;
   logic [2:0][31:0]          p4_dir_ff;
   logic [31:0]               p4_tl_ff, p5_tl_ff, p6_tl_ff;
   logic [31:0]               p4_th_ff, p5_th_ff, p6_th_ff;
   logic signed [31:0]        inv_ff   [3];
   logic signed [63:0]        prod_hi_ff [3];
   logic signed [63:0]        prod_lo_ff [3];
   logic signed [31:0]        tmin_ff  [3];
   logic signed [31:0]        tmax_ff  [3];
   logic signed [31:0]        entry4_ff, entry5_ff, entry6_ff;
   logic                      ovl4_ff, ovl5_ff, ovl6_ff;
   logic signed [63:0]        pprod_ff [3];
   logic [2:0][31:0]          pt_ff;

   rbsi_pkg::rsp_type         rsp_ff, rsp_in;
   logic                      rsp_v_ff;
   logic                      ovl_out_ff;
   logic                      rsp_cleared;

   logic signed [31:0]        inv_in   [3];
   logic signed [31:0]        tmin_in  [3];
   logic signed [31:0]        tmax_in  [3];
   logic signed [31:0]        entry_in;
   logic                      ovl_in;
   logic [2:0][31:0]          pt_in;
   logic [2:0]                near_hi;
   logic [2:0]                near_lo;

   // The whole pipeline moves when the output register is free or being taken.
   assign adv       = !rsp_v_ff || rsp_ready;
   assign q_pop     = adv && q_valid;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // Restoring divider, one quotient bit per stage for each axis.
   for (genvar s = 0; s < DW; s++) begin : g_div
      rbsi_pkg::work_type  w_src;
      logic [2:0][31:0]    rem_src;
      logic [2:0][DW-1:0]  q_src;
      logic                v_src;
      logic                bit_in;
      logic [2:0][31:0]    rem_nxt;
      logic [2:0][DW-1:0]  q_nxt;

      assign bit_in = (s == 0);

      if (s == 0) begin : g_first
         assign w_src   = q_data;
         assign rem_src = '0;
         assign q_src   = '0;
         assign v_src   = q_valid;
      end else begin : g_rest
         assign w_src   = div_w_ff[s-1];
         assign rem_src = div_rem_ff[s-1];
         assign q_src   = div_q_ff[s-1];
         assign v_src   = div_v_ff[s-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            logic [32:0] shifted;
            logic        ge;
            shifted    = {rem_src[i], bit_in};
            ge         = shifted >= {1'b0, w_src.dmag[i]};
            rem_nxt[i] = ge ? 32'(shifted - {1'b0, w_src.dmag[i]}) : shifted[31:0];
            q_nxt[i]   = {q_src[i][DW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[s] <= 1'b0;
         end else if (adv) begin
            div_v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_w_ff[s]   <= w_src;
            div_rem_ff[s] <= rem_nxt;
            div_q_ff[s]   <= q_nxt;
         end
      end
   end

   // Signed, saturated reciprocal, or the clamp for a tiny direction.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [63:0] q64;
         q64 = {{(64 - DW){1'b0}}, div_q_ff[DW-1][i]};
         if (div_w_ff[DW-1].dsmall[i]) begin
            inv_in[i] = cfg.inv_dir_clamp;
         end else if (div_w_ff[DW-1].dneg[i]) begin
            inv_in[i] = (q64 > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q64[31:0]);
         end else begin
            inv_in[i] = (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[31:0];
         end
      end
   end

   // Per-axis slab entry and exit after the offset products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [31:0] va;
         logic signed [31:0] vb;
         va = rbsi_pkg::sat32(prod_hi_ff[i] >>> FRAC_BITS);
         vb = rbsi_pkg::sat32(prod_lo_ff[i] >>> FRAC_BITS);
         tmin_in[i] = (vb < va) ? vb : va;
         tmax_in[i] = (vb >= va) ? vb : va;
      end
   end

   // Largest entry, smallest exit and the overlap test.
   always_comb begin
      logic signed [31:0] ex;
      entry_in = tmin_ff[0];
      ex       = tmax_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (tmin_ff[i] > entry_in) begin
            entry_in = tmin_ff[i];
         end
         if (tmax_ff[i] < ex) begin
            ex = tmax_ff[i];
         end
      end
      ovl_in = ex >= entry_in;
   end

   // Entry point: origin plus scaled direction, zero when there is no overlap.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [31:0] step;
         logic signed [63:0] sum;
         step = rbsi_pkg::sat32(pprod_ff[i] >>> FRAC_BITS);
         sum  = 64'($signed(p5_org_ff[i])) + 64'(step);
         pt_in[i] = ovl5_ff ? rbsi_pkg::sat32(sum) : 32'h0;
      end
   end

   // Face search against both planes of each axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [32:0] dh;
         logic signed [32:0] dl;
         logic [32:0]        mh;
         logic [32:0]        ml;
         dh = $signed({pt_ff[i][31], pt_ff[i]}) - $signed({cfg.box_max[i][31], cfg.box_max[i]});
         dl = $signed({pt_ff[i][31], pt_ff[i]}) - $signed({cfg.box_min[i][31], cfg.box_min[i]});
         mh = dh[32] ? 33'(-dh) : dh;
         ml = dl[32] ? 33'(-dl) : dl;
         near_hi[i] = mh < {2'b00, cfg.snap_margin};
         near_lo[i] = ml < {2'b00, cfg.snap_margin};
      end
   end

   always_comb begin
      rsp_in.hit_t   = entry6_ff;
      rsp_in.point_x = pt_ff[0];
      rsp_in.point_y = pt_ff[1];
      rsp_in.point_z = pt_ff[2];
      rsp_in.hit     = ovl6_ff && (entry6_ff > $signed(p6_tl_ff))
                       && (entry6_ff < $signed(p6_th_ff));
      priority if (!ovl6_ff) begin
         rsp_in.face_code = rbsi_pkg::FACE_NONE;
      end else if (near_hi[2]) begin
         rsp_in.face_code = rbsi_pkg::FACE_POS_Z;
      end else if (near_lo[2]) begin
         rsp_in.face_code = rbsi_pkg::FACE_NEG_Z;
      end else if (near_hi[1]) begin
         rsp_in.face_code = rbsi_pkg::FACE_POS_Y;
      end else if (near_lo[1]) begin
         rsp_in.face_code = rbsi_pkg::FACE_NEG_Y;
      end else if (near_hi[0]) begin
         rsp_in.face_code = rbsi_pkg::FACE_POS_X;
      end else if (near_lo[0]) begin
         rsp_in.face_code = rbsi_pkg::FACE_NEG_X;
      end else begin
         rsp_in.face_code = rbsi_pkg::FACE_NONE;
      end
   end

   // Valid bits of the post-divider stages and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff   <= {p_v_ff[4:0], div_v_ff[DW-1]};
         rsp_v_ff <= p_v_ff[5];
      end
   end

   // Datapath registers of the post-divider stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_w_ff <= div_w_ff[DW-1];
         p2_w_ff <= p1_w_ff;
         p3_w_ff <= p2_w_ff;
         for (int i = 0; i < 3; i++) begin
            inv_ff[i]     <= inv_in[i];
            prod_hi_ff[i] <= $signed(p1_w_ff.off_hi[i]) * inv_ff[i];
            prod_lo_ff[i] <= $signed(p1_w_ff.off_lo[i]) * inv_ff[i];
            tmin_ff[i]    <= tmin_in[i];
            tmax_ff[i]    <= tmax_in[i];
            pprod_ff[i]   <= $signed(p4_dir_ff[i]) * entry4_ff;
         end
         entry4_ff  <= entry_in;
         ovl4_ff    <= ovl_in;
         p4_org_ff  <= p3_w_ff.org;
         p4_dir_ff  <= p3_w_ff.dir;
         p4_tl_ff   <= p3_w_ff.t_low;
         p4_th_ff   <= p3_w_ff.t_high;
         entry5_ff  <= entry4_ff;
         ovl5_ff    <= ovl4_ff;
         p5_org_ff  <= p4_org_ff;
         p5_tl_ff   <= p4_tl_ff;
         p5_th_ff   <= p4_th_ff;
         pt_ff      <= pt_in;
         entry6_ff  <= entry5_ff;
         ovl6_ff    <= ovl5_ff;
         p6_tl_ff   <= p5_tl_ff;
         p6_th_ff   <= p5_th_ff;
         rsp_ff     <= rsp_in;
         ovl_out_ff <= ovl6_ff;
      end
   end

   // A result without overlap carries no hit, no face and a zero point.
   assign rsp_cleared = !rsp_ff.hit && rsp_ff.face_code == rbsi_pkg::FACE_NONE
                        && rsp_ff.point_x == 0;

   // Without overlap the hit, the face code and the point's x coordinate are all zero.
   `RBSI_ASSERT_NOW(a_no_ovl_zero, clock, reset, rsp_v_ff && !ovl_out_ff,
                    rsp_cleared, "non-overlap result not cleared")

   // Face codes stay within the defined set.
   `RBSI_ASSERT_NOW(a_face_range, clock, reset, rsp_v_ff,
                    rsp_ff.face_code <= rbsi_pkg::FACE_NEG_X, "face code out of range")

   // A stalled output freezes the valid bits and the held result.
   `RBSI_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_v_ff && !rsp_ready,
                     $stable(p_v_ff) && $stable(rsp_ff), "pipeline moved during stall")

endmodule
